FILE: rtl/core/aos_pkg.sv
// Shared constants, types and command codes of the audio output stage.
package aos_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 24;

   localparam int ACC_BITS   = 32;
   localparam int GAIN_BITS  = COEF_FRAC_BITS + 1;
   localparam int QUOT_BITS  = SAMPLE_BITS - 2;
   localparam int DEN_BITS   = ACC_BITS + 1;
   localparam int PROD_BITS  = ACC_BITS + GAIN_BITS;
   localparam int FB_BITS    = PROD_BITS - COEF_FRAC_BITS;
   localparam int SUM_BITS   = FB_BITS + 2;
   localparam int DCNT_BITS  = $clog2(QUOT_BITS);
   localparam int CSR_IDX_BITS = 1;

   localparam logic [GAIN_BITS-1:0] ONE_GAIN = GAIN_BITS'(1) << COEF_FRAC_BITS;
   localparam logic [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [DEN_BITS-1:0]  DIV_BIAS = DEN_BITS'(1) << (SAMPLE_BITS - 3);
   localparam logic [DCNT_BITS-1:0] DCNT_LAST = DCNT_BITS'(QUOT_BITS - 1);

   localparam logic signed [SUM_BITS-1:0] ACC_MAX_EXT =
      {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] ACC_MIN_EXT =
      {{(SUM_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

   localparam logic [COEF_FRAC_BITS-1:0] ALPHA_RESET = COEF_FRAC_BITS'(16766235);
   localparam logic [GAIN_BITS-1:0]      STEP_RESET  = GAIN_BITS'(69905);

   localparam logic [CSR_IDX_BITS-1:0] CSR_DC_ALPHA  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAMP_STEP = 1'd1;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_STEAL  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_STEAL  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]                    cmd;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } cmd_entry_type;

   typedef struct packed {
      logic clear;
      logic mul_fb;
      logic mul_gain;
      logic sum;
      logic div_step;
   } lane_ctrl_type;

endpackage

FILE: rtl/core/aos_front.sv
// Input acceptance, op classification and the command queue.
module aos_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_raw_left,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_raw_right,
   output logic                   q_valid,
   output aos_pkg::cmd_entry_type q_entry,
   input  logic                   q_pop
);
   import aos_pkg::*;

   cmd_entry_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   logic                    keep;
   logic [1:0]              cmd;
   logic                    push;

   always_comb begin
      keep = 1'b1;
      cmd  = CMD_SAMPLE;
      unique case (req_op)
         OP_SAMPLE: cmd = CMD_SAMPLE;
         OP_STEAL:  cmd = CMD_STEAL;
         OP_CLEAR:  cmd = CMD_CLEAR;
         default:   keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cmd: cmd, left: req_raw_left, right: req_raw_right};
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

FILE: rtl/core/aos_lane.sv
// One channel datapath: DC blocker, iterative soft-clip divider, gain multiply.
module aos_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  aos_pkg::lane_ctrl_type ctrl,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0]  x,
   input  logic [aos_pkg::COEF_FRAC_BITS-1:0]      alpha,
   input  logic [aos_pkg::GAIN_BITS-1:0]           gain,
   output logic signed [aos_pkg::SAMPLE_BITS-1:0]  result
);
   import aos_pkg::*;

   logic signed [SAMPLE_BITS-1:0] pin_ff;
   logic signed [ACC_BITS-1:0]    pout_ff;
   logic [PROD_BITS-1:0]          prod_ff, prod_in;
   logic                          neg_ff, neg_in;
   logic [DEN_BITS-1:0]           rem_ff, rem_in;
   logic [DEN_BITS-1:0]           den_ff;
   logic [QUOT_BITS-1:0]          q_ff, q_in;

   logic [ACC_BITS-1:0]           pout_mag;
   logic [ACC_BITS-1:0]           mul_a;
   logic [GAIN_BITS-1:0]          mul_b;
   logic [PROD_BITS-1:0]          rnd;
   logic [FB_BITS-1:0]            fb_mag;
   logic signed [SUM_BITS-1:0]    fb;
   logic signed [SUM_BITS-1:0]    total;
   logic signed [ACC_BITS-1:0]    y;
   logic [ACC_BITS-1:0]           y_mag;
   logic [DEN_BITS:0]             rem_sh;
   logic [DEN_BITS:0]             rem_diff;
   logic [SAMPLE_BITS-1:0]        res_mag;

   assign pout_mag = pout_ff[ACC_BITS-1] ? (~pout_ff + 1'b1) : pout_ff;
   assign mul_a    = ctrl.mul_gain ? ACC_BITS'(q_ff) : pout_mag;
   assign mul_b    = ctrl.mul_gain ? gain : GAIN_BITS'(alpha);

   assign rnd    = (prod_ff + RND_HALF) >> COEF_FRAC_BITS;
   assign fb_mag = rnd[FB_BITS-1:0];
   assign fb     = neg_ff ? -$signed({2'b00, fb_mag}) : $signed({2'b00, fb_mag});
   assign total  = SUM_BITS'(x) - SUM_BITS'(pin_ff) + fb;

   always_comb begin
      if (total > ACC_MAX_EXT) begin
         y = ACC_MAX_EXT[ACC_BITS-1:0];
      end else if (total < ACC_MIN_EXT) begin
         y = ACC_MIN_EXT[ACC_BITS-1:0];
      end else begin
         y = total[ACC_BITS-1:0];
      end
   end

   assign y_mag    = y[ACC_BITS-1] ? (~y + 1'b1) : y;
   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   assign res_mag = rnd[SAMPLE_BITS-1:0];
   assign result  = neg_ff ? -$signed(res_mag) : $signed(res_mag);

   always_comb begin
      prod_in = prod_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (ctrl.mul_fb || ctrl.mul_gain) begin
         prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
      if (ctrl.mul_fb) begin
         neg_in = pout_ff[ACC_BITS-1];
      end
      if (ctrl.sum) begin
         neg_in = y[ACC_BITS-1];
         rem_in = DEN_BITS'(y_mag);
         q_in   = '0;
      end
      if (ctrl.div_step) begin
         if (!rem_diff[DEN_BITS]) begin
            rem_in = rem_diff[DEN_BITS-1:0];
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_BITS-1:0];
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      if (ctrl.sum) begin
         den_ff <= DEN_BITS'(y_mag) + DIV_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         pin_ff  <= '0;
         pout_ff <= '0;
      end else if (ctrl.sum) begin
         pin_ff  <= x;
         pout_ff <= y;
      end
   end

endmodule

FILE: rtl/core/aos_back.sv
// Command sequencer, steal-ramp gain, both channel lanes and result register.
module aos_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  aos_pkg::cmd_entry_type q_entry,
   output logic                   q_pop,
   input  logic [aos_pkg::COEF_FRAC_BITS-1:0] dc_alpha,
   input  logic [aos_pkg::GAIN_BITS-1:0]      ramp_step,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [aos_pkg::SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [aos_pkg::SAMPLE_BITS-1:0] rsp_out_right
);
   import aos_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FB    = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_GMUL  = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [DCNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [GAIN_BITS-1:0]          gain_ff, gain_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_left_ff, x_right_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   logic signed [SAMPLE_BITS-1:0] res_left, res_right;
   lane_ctrl_type                 ctrl;
   logic                          load;
   logic                          take;
   logic [GAIN_BITS:0]            gain_sum;

   assign gain_sum = {1'b0, gain_ff} + {1'b0, ramp_step};
   assign load     = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);
   assign take     = q_valid && (state_ff == ST_IDLE);
   assign q_pop    = take;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      gain_in      = gain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (q_entry.cmd)
                  CMD_STEAL: begin
                     ctrl.clear = 1'b1;
                     gain_in    = '0;
                  end
                  CMD_CLEAR: ctrl.clear = 1'b1;
                  default:   state_in = ST_FB;
               endcase
            end
         end
         ST_FB: begin
            ctrl.mul_fb = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            ctrl.sum = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_LAST) begin
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: begin
            ctrl.mul_gain = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (gain_ff < ONE_GAIN) begin
                  gain_in = (gain_sum > {1'b0, ONE_GAIN}) ? ONE_GAIN : gain_sum[GAIN_BITS-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         gain_ff      <= ONE_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_left_ff  <= q_entry.left;
         x_right_ff <= q_entry.right;
      end
      if (load) begin
         out_left_ff  <= res_left;
         out_right_ff <= res_right;
      end
   end

   aos_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (x_left_ff),
      .alpha  (dc_alpha),
      .gain   (gain_ff),
      .result (res_left)
   );

   aos_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (x_right_ff),
      .alpha  (dc_alpha),
      .gain   (gain_ff),
      .result (res_right)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= ONE_GAIN)
      else $error("ramp gain above unity");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result load not shown on output");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DCNT_LAST))
      else $error("divider step count overrun");

endmodule

FILE: rtl/core/audio_output_stage_dc_clip_ramp.sv
// Stereo output stage top: configuration registers, command front end and datapath back end.
// The back end takes a queued command only when idle and holds a finished result until the
// output is free; samples pass the 22-step soft-clip divider that both lanes run in step;
// steal and clear commands give no result.
// Reset (synchronous): filter state clears to zero, gain is 1.0, registers take their
// defaults, the command queue and output register are emptied.
module audio_output_stage_dc_clip_ramp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_raw_left,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_raw_right,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [aos_pkg::SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [aos_pkg::SAMPLE_BITS-1:0] rsp_out_right,
   input  logic                   csr_we,
   input  logic [aos_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [aos_pkg::GAIN_BITS-1:0]    csr_wdata
);
   import aos_pkg::*;

   logic [COEF_FRAC_BITS-1:0] alpha_ff;
   logic [GAIN_BITS-1:0]      step_ff;
   logic                      q_valid;
   logic                      q_pop;
   cmd_entry_type             q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         step_ff  <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DC_ALPHA:  alpha_ff <= csr_wdata[COEF_FRAC_BITS-1:0];
            CSR_RAMP_STEP: step_ff  <= csr_wdata;
            default:       ;
         endcase
      end
   end

   aos_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_raw_left  (req_raw_left),
      .req_raw_right (req_raw_right),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   aos_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .dc_alpha      (alpha_ff),
      .ramp_step     (step_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right)
   );

endmodule
